// ----- rtl/csfw_pkg.sv -----
// package for the counting semaphore with fifo wait queue: constants, words, control types
`timescale 1ns / 1ps
package csfw_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int ID_BITS = 8;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
	localparam int HELD_W = 9;
	localparam int COUNT_W = 8;
	localparam logic [COUNT_W-1:0] INIT_RESET = COUNT_W'(1);

	typedef enum logic {
		OP_WAIT   = 1'b0,
		OP_SIGNAL = 1'b1
	} op_e;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_FULL = 2'd1,
		STAT_SAT  = 2'd2
	} status_e;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RESP = 1'b1
	} state_t;

	typedef struct packed {
		logic       op;
		logic [7:0] requester_id;
	} req_t;

	typedef struct packed {
		logic       granted;
		logic       queued;
		logic       woken_valid;
		logic [7:0] woken_id;
		logic [1:0] status;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic    load;
		logic    grant;
		logic    push;
		logic    pop;
		logic    release_tok;
		status_e status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic tok_free;
		logic q_empty;
		logic q_full;
		logic held_min;
	} stat_t;

endpackage

// ----- rtl/csfw_ctrl.sv -----
// controller: decodes each accepted request into datapath commands and times the result strobe
`timescale 1ns / 1ps
module csfw_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            op,
	input  csfw_pkg::stat_t stat,
	output csfw_pkg::cmd_t  cmd,
	output logic            busy,
	output logic            done
);
	import csfw_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.status = STAT_OK;
		state_d = ST_IDLE;
		// busy is never raised, so a new request can always be taken
		busy = 1'b0;
		done = (state_q == ST_RESP);
		if (start) begin
			state_d = ST_RESP;
			cmd.load = 1'b1;
			case (op_e'(op))
				OP_WAIT: begin
					if (stat.tok_free) begin
						cmd.grant = 1'b1;
					end else if (!stat.q_full) begin
						cmd.push = 1'b1;
					end else begin
						cmd.status = STAT_FULL;
					end
				end
				OP_SIGNAL: begin
					if (!stat.q_empty) begin
						cmd.pop = 1'b1;
					end else if (!stat.held_min) begin
						cmd.release_tok = 1'b1;
					end else begin
						cmd.status = STAT_SAT;
					end
				end
				default: begin
					cmd.status = STAT_OK;
				end
			endcase
		end
	end

endmodule

// ----- rtl/csfw_dp.sv -----
// datapath: token count, wait queue storage and pointers, result word register
`timescale 1ns / 1ps
module csfw_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [7:0]                 cfg_wdata,
	input  logic [csfw_pkg::ID_BITS-1:0] push_id,
	input  csfw_pkg::cmd_t             cmd,
	output csfw_pkg::stat_t            stat,
	output csfw_pkg::rsp_t             rsp
);
	import csfw_pkg::*;

	logic [COUNT_W-1:0] init_q;
	logic [HELD_W-1:0]  held_q;
	logic [PTR_W-1:0]   head_q, tail_q;
	logic [OCC_W-1:0]   occ_q;
	logic [ID_BITS-1:0] wait_mem [QUEUE_DEPTH];
	rsp_t               rsp_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		stat.tok_free = ($signed(held_q) < $signed({1'b0, init_q}))
			&& ($signed(held_q) < $signed(HELD_W'(255)));
		stat.q_empty  = (occ_q == '0);
		stat.q_full   = (occ_q == OCC_W'(QUEUE_DEPTH));
		stat.held_min = (held_q == {1'b1, {(HELD_W-1){1'b0}}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= INIT_RESET;
			held_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			occ_q  <= '0;
		end else begin
			if (cfg_we) begin
				init_q <= cfg_wdata;
			end
			if (cmd.grant) begin
				held_q <= held_q + 1'b1;
			end else if (cmd.release_tok) begin
				held_q <= held_q - 1'b1;
			end
			if (cmd.push) begin
				tail_q <= ptr_inc(tail_q);
				occ_q  <= occ_q + 1'b1;
			end else if (cmd.pop) begin
				head_q <= ptr_inc(head_q);
				occ_q  <= occ_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			wait_mem[tail_q] <= push_id;
		end
		if (cmd.load) begin
			rsp_q <= '{
				granted:     cmd.grant,
				queued:      cmd.push,
				woken_valid: cmd.pop,
				woken_id:    (cmd.pop ? 8'(wait_mem[head_q]) : 8'd0),
				status:      cmd.status
			};
		end
	end

	assign rsp = rsp_q;

endmodule

// ----- rtl/counting_semaphore_fifo_wait_unit.sv -----
// top level of the counting semaphore with fifo wait queue
//
// usage:
//   requests come in on req (op: wait or signal, requester_id) and are taken
//   at a clock edge where start is high and busy is low. busy stays low: the
//   decode, token count update and queue push or pop all take effect at the
//   edge where the request is taken, so a request can be issued every cycle.
//   each request yields exactly one result word on rsp, shown for one cycle
//   with done high, in the cycle right after the request was taken. the
//   receiver cannot stall; a word not taken in its cycle is gone.
//   a wait is granted while held tokens stay below initial_count, otherwise
//   its id is queued, or dropped with status full when the 16-deep queue is
//   full. a signal wakes the queue head if any, else returns a token, with
//   status saturated when the held count sits at its negative bound.
//   initial_count is written through cfg_we / cfg_wdata while idle.
//   reset: held count 0, queue empty, initial_count 1; queue storage is not
//   cleared and is only read once written.
`timescale 1ns / 1ps
module counting_semaphore_fifo_wait_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  csfw_pkg::req_t req,
	input  logic           cfg_we,
	input  logic [7:0]     cfg_wdata,
	output logic           done,
	output csfw_pkg::rsp_t rsp
);
	import csfw_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	csfw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (req.op),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	csfw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push_id   (req.requester_id[ID_BITS-1:0]),
		.cmd       (cmd),
		.stat      (stat),
		.rsp       (rsp)
	);

endmodule
